// ----- rtl/core/yuyv_pkg.sv -----
// ----------------------------------------------------------------------------
// yuyv_pkg
// shared widths, coefficients, types and arithmetic helpers for the
// yuyv 4:2:2 to rgb888 converter
// ----------------------------------------------------------------------------
package yuyv_pkg;

    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned DIFF_W        = 9;   // chroma minus offset, signed
    localparam int unsigned PROD_W        = 18;  // coefficient products, signed
    localparam int unsigned SUM_W         = 19;  // scaled luma plus product, signed

    localparam int unsigned CHROMA_OFFSET = 128;
    localparam int unsigned COEF_RV       = 358;
    localparam int unsigned COEF_GV       = 182;
    localparam int unsigned COEF_GU       = 88;
    localparam int unsigned COEF_BU       = 453;
    localparam int unsigned UNITY_SHIFT   = 8;   // divide by 256
    localparam int unsigned CHAN_MAX      = 255;

    localparam int unsigned QUEUE_DEPTH   = 2;

    // one complete yuyv pair, as handed from front to back
    typedef struct packed {
        logic [BYTE_W-1:0] luma_even;
        logic [BYTE_W-1:0] luma_odd;
        logic [BYTE_W-1:0] cb;
        logic [BYTE_W-1:0] cr;
    } pair_t;

    // queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic signed [PROD_W-1:0] chroma_diff(input logic [BYTE_W-1:0] c);
        logic signed [PROD_W-1:0] ext;
        ext = $signed({{(PROD_W-BYTE_W){1'b0}}, c});
        return ext - $signed(PROD_W'(CHROMA_OFFSET));
    endfunction

    function automatic logic signed [PROD_W-1:0] mul_coef(
        input logic signed [PROD_W-1:0] d,
        input int unsigned               coef
    );
        return d * $signed(PROD_W'(coef));
    endfunction

    // negative sums clamp to zero, so floor and truncation agree here
    function automatic logic [BYTE_W-1:0] clamp_channel(
        input logic [BYTE_W-1:0]        y,
        input logic signed [PROD_W-1:0] prod
    );
        logic signed [SUM_W-1:0] sum;
        logic [SUM_W-1:0]        q;
        sum = $signed({{(SUM_W-BYTE_W-UNITY_SHIFT){1'b0}}, y, {UNITY_SHIFT{1'b0}}})
              + SUM_W'(prod);
        q   = SUM_W'(sum >>> UNITY_SHIFT);
        if (sum < 0)
            return '0;
        else if (q > SUM_W'(CHAN_MAX))
            return BYTE_W'(CHAN_MAX);
        else
            return q[BYTE_W-1:0];
    endfunction

endpackage

// ----- rtl/core/yuyv_ifs.sv -----
// ----------------------------------------------------------------------------
// yuyv channel interfaces
// valid/ready channels for incoming yuyv pixels and outgoing rgb pixels
// ----------------------------------------------------------------------------
interface yuyv_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] luma;
    logic [7:0] chroma;

    modport source (output valid, output luma, output chroma, input ready);
    modport sink   (input valid, input luma, input chroma, output ready);
endinterface

interface yuyv_rgb_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_of_pair;

    modport source (output valid, output red, output green, output blue,
                    output last_of_pair, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input last_of_pair, output ready);
endinterface

// ----- rtl/core/yuyv_front.sv -----
// ----------------------------------------------------------------------------
// yuyv_front
// accepts pixel requests, holds the even pixel, pushes complete pairs
// ----------------------------------------------------------------------------
module yuyv_front
    import yuyv_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    yuyv_pix_if.sink      pix_in,
    input  queue_status_t q_status,
    output logic          push,
    output pair_t         push_data
);

    logic              odd_phase_reg;
    logic              odd_phase_next;
    logic [BYTE_W-1:0] held_luma_reg;
    logic [BYTE_W-1:0] held_luma_next;
    logic [BYTE_W-1:0] held_cb_reg;
    logic [BYTE_W-1:0] held_cb_next;
    logic              accept;

    // an even pixel only lands in the holding registers
    assign pix_in.ready = !odd_phase_reg || !q_status.full;
    assign accept       = pix_in.valid && pix_in.ready;
    assign push         = accept && odd_phase_reg;

    assign push_data.luma_even = held_luma_reg;
    assign push_data.luma_odd  = pix_in.luma;
    assign push_data.cb        = held_cb_reg;
    assign push_data.cr        = pix_in.chroma;

    always_comb
    begin
        odd_phase_next = odd_phase_reg;
        held_luma_next = held_luma_reg;
        held_cb_next   = held_cb_reg;
        if (accept)
        begin
            odd_phase_next = !odd_phase_reg;
            if (!odd_phase_reg)
            begin
                held_luma_next = pix_in.luma;
                held_cb_next   = pix_in.chroma;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            odd_phase_reg <= 1'b0;
            held_luma_reg <= '0;
            held_cb_reg   <= '0;
        end
        else
        begin
            odd_phase_reg <= odd_phase_next;
            held_luma_reg <= held_luma_next;
            held_cb_reg   <= held_cb_next;
        end
    end

    a_phase_flips: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> odd_phase_reg != $past(odd_phase_reg))
        else $error("phase did not alternate on accepted pixel");

    a_even_never_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        !pix_in.ready |-> odd_phase_reg)
        else $error("even pixel stalled");

endmodule

// ----- rtl/core/yuyv_queue.sv -----
// ----------------------------------------------------------------------------
// yuyv_queue
// small first-word-fall-through queue of yuyv pairs
// ----------------------------------------------------------------------------
module yuyv_queue
    import yuyv_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  pair_t         push_data,
    input  logic          pop,
    output pair_t         head,
    output queue_status_t status
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    pair_t            mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign head         = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && status.full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && status.empty))
        else $error("pop from empty queue");

endmodule

// ----- rtl/core/yuyv_back.sv -----
// ----------------------------------------------------------------------------
// yuyv_back
// splits each pair into two pixels and converts them in a two-stage pipe
// ----------------------------------------------------------------------------
module yuyv_back
    import yuyv_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  pair_t         head,
    input  queue_status_t q_status,
    output logic          pop,
    yuyv_rgb_if.source    pix_out
);

    // product stage
    logic                     sel_reg;
    logic                     sel_next;
    logic                     a_valid_reg;
    logic                     a_valid_next;
    logic [BYTE_W-1:0]        a_luma_reg;
    logic [BYTE_W-1:0]        a_luma_next;
    logic                     a_last_reg;
    logic                     a_last_next;
    logic signed [PROD_W-1:0] a_rv_reg;
    logic signed [PROD_W-1:0] a_rv_next;
    logic signed [PROD_W-1:0] a_g_reg;
    logic signed [PROD_W-1:0] a_g_next;
    logic signed [PROD_W-1:0] a_bu_reg;
    logic signed [PROD_W-1:0] a_bu_next;

    // output register
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [BYTE_W-1:0] red_reg;
    logic [BYTE_W-1:0] red_next;
    logic [BYTE_W-1:0] green_reg;
    logic [BYTE_W-1:0] green_next;
    logic [BYTE_W-1:0] blue_reg;
    logic [BYTE_W-1:0] blue_next;
    logic              last_reg;
    logic              last_next;

    logic                     out_adv;
    logic                     a_adv;
    logic                     load_a;
    logic signed [PROD_W-1:0] u;
    logic signed [PROD_W-1:0] v;

    assign out_adv = !out_valid_reg || pix_out.ready;
    assign a_adv   = !a_valid_reg || out_adv;
    assign load_a  = a_adv && !q_status.empty;
    assign pop     = load_a && sel_reg;

    assign u = chroma_diff(head.cb);
    assign v = chroma_diff(head.cr);

    always_comb
    begin
        sel_next     = sel_reg;
        a_valid_next = a_valid_reg;
        a_luma_next  = a_luma_reg;
        a_last_next  = a_last_reg;
        a_rv_next    = a_rv_reg;
        a_g_next     = a_g_reg;
        a_bu_next    = a_bu_reg;
        if (a_adv)
            a_valid_next = !q_status.empty;
        if (load_a)
        begin
            sel_next    = !sel_reg;
            a_luma_next = sel_reg ? head.luma_odd : head.luma_even;
            a_last_next = sel_reg;
            a_rv_next   = mul_coef(v, COEF_RV);
            a_g_next    = mul_coef(v, COEF_GV) + mul_coef(u, COEF_GU);
            a_bu_next   = mul_coef(u, COEF_BU);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        red_next       = red_reg;
        green_next     = green_reg;
        blue_next      = blue_reg;
        last_next      = last_reg;
        if (out_adv)
        begin
            out_valid_next = a_valid_reg;
            red_next       = clamp_channel(a_luma_reg, a_rv_reg);
            green_next     = clamp_channel(a_luma_reg, -a_g_reg);
            blue_next      = clamp_channel(a_luma_reg, a_bu_reg);
            last_next      = a_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg       <= 1'b0;
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sel_reg       <= sel_next;
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_luma_reg <= a_luma_next;
        a_last_reg <= a_last_next;
        a_rv_reg   <= a_rv_next;
        a_g_reg    <= a_g_next;
        a_bu_reg   <= a_bu_next;
        red_reg    <= red_next;
        green_reg  <= green_next;
        blue_reg   <= blue_next;
        last_reg   <= last_next;
    end

    assign pix_out.valid        = out_valid_reg;
    assign pix_out.red          = red_reg;
    assign pix_out.green        = green_reg;
    assign pix_out.blue         = blue_reg;
    assign pix_out.last_of_pair = last_reg;

    a_pair_held: assert property (@(posedge clk) disable iff (!rst_n)
        sel_reg |-> !q_status.empty)
        else $error("second pixel pending with no pair in queue");

    a_pop_after_odd: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> a_valid_reg && a_last_reg)
        else $error("pair popped without its odd pixel in the pipe");

endmodule

// ----- rtl/core/yuyv_to_rgb_converter_core.sv -----
// ----------------------------------------------------------------------------
// yuyv_to_rgb_converter_core
// packed yuyv 4:2:2 stream to rgb888 with bt.601-style integer coefficients
// ----------------------------------------------------------------------------
// order: once the odd pixel is accepted, its pair is queued; the even
//   pixel passes the product stage and output register, the odd one after it
// throughput: one pixel in and one pixel out per cycle, sustained while
//   the output is ready; the back part emits each pair one pixel at a time
// reset: asynchronous, active low; clears the phase, the held pixel, the
//   queue and all pipe valid bits, no clearing pass needed
// ----------------------------------------------------------------------------
module yuyv_to_rgb_converter_core
    import yuyv_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    yuyv_pix_if.sink   pix_in,
    yuyv_rgb_if.source pix_out
);

    // front to back hand-over
    logic          push;
    pair_t         push_data;
    logic          pop;
    pair_t         head;
    queue_status_t q_status;

    // front: takes each pixel request, keeps the even pixel, forms a pair
    yuyv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_in    (pix_in),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    // short queue so the two sides stall independently
    yuyv_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    // back: products stage, then sum, clamp and output register
    yuyv_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .pix_out  (pix_out)
    );

endmodule

// ----- bench/yuyv_rgb_checker.sv -----
// ----------------------------------------------------------------------------
// yuyv_rgb_checker
// watches both channels of the converter, works out the rgb pair that each
// odd pixel should produce and compares every outgoing pixel against it
// ----------------------------------------------------------------------------
module yuyv_rgb_checker
    import yuyv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    yuyv_pix_if        pix,
    yuyv_rgb_if        rgb,
    output int         mismatch_count,
    output int         rgb_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int K_RV   = int'(COEF_RV);
    localparam int K_GV   = int'(COEF_GV);
    localparam int K_GU   = int'(COEF_GU);
    localparam int K_BU   = int'(COEF_BU);
    localparam int OFFSET = int'(CHROMA_OFFSET);
    localparam int SCALE  = 1 << UNITY_SHIFT;

    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic              last_of_pair;
    } rgb_pix_t;

    // predictor state
    logic              odd_phase;
    logic [BYTE_W-1:0] held_luma;
    logic [BYTE_W-1:0] held_cb;

    rgb_pix_t          rgb_expected_q[$];
    rgb_pix_t          want;
    int                errs = 0;
    int                u_diff;
    int                v_diff;

    // scale back by 256 truncating toward zero, then saturate
    function automatic logic [BYTE_W-1:0] sat_channel(input int scaled);
        int q;
        q = scaled / SCALE;
        if (q < 0)
            return '0;
        if (q > 255)
            return 8'd255;
        return q[BYTE_W-1:0];
    endfunction

    function automatic rgb_pix_t yuv_to_rgb(input logic [BYTE_W-1:0] y, input int u,
                                            input int v, input logic last);
        rgb_pix_t p;
        int       ys;
        ys             = int'(y) * SCALE;
        p.red          = sat_channel(ys + K_RV * v);
        p.green        = sat_channel(ys - K_GV * v - K_GU * u);
        p.blue         = sat_channel(ys + K_BU * u);
        p.last_of_pair = last;
        return p;
    endfunction

    task automatic check_field(input string fname, input int exp_val, input int act_val);
        if (exp_val != act_val)
        begin
            errs++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, fname, exp_val, act_val);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            odd_phase = 1'b0;
            held_luma = '0;
            held_cb   = '0;
            rgb_expected_q.delete();
        end
        else
        begin
            if (pix.valid && pix.ready)
            begin
                if (!odd_phase)
                begin
                    held_luma = pix.luma;
                    held_cb   = pix.chroma;
                    odd_phase = 1'b1;
                end
                else
                begin
                    u_diff = int'(held_cb) - OFFSET;
                    v_diff = int'(pix.chroma) - OFFSET;
                    rgb_expected_q = {rgb_expected_q,
                                      yuv_to_rgb(held_luma, u_diff, v_diff, 1'b0),
                                      yuv_to_rgb(pix.luma, u_diff, v_diff, 1'b1)};
                    odd_phase = 1'b0;
                end
            end

            if (rgb.valid && rgb.ready)
            begin
                if (rgb_expected_q.size() == 0)
                begin
                    errs++;
                    $display("%0t ns: unexpected rgb pixel, expected none, actual %0d/%0d/%0d/%0d",
                             $time, rgb.red, rgb.green, rgb.blue, rgb.last_of_pair);
                end
                else
                begin
                    want = rgb_expected_q.pop_front();
                    check_field("red", want.red, rgb.red);
                    check_field("green", want.green, rgb.green);
                    check_field("blue", want.blue, rgb.blue);
                    check_field("last_of_pair", want.last_of_pair, rgb.last_of_pair);
                end
            end
        end
        mismatch_count <= errs;
        rgb_pending    <= rgb_expected_q.size();
    end

endmodule

// ----- bench/tb_yuyv_to_rgb_converter_core.sv -----
// ----------------------------------------------------------------------------
// tb_yuyv_to_rgb_converter_core
// drives yuyv pixel pairs into the converter, directed corners first and then
// random pairs, with random idling on both channels; the checker beside the
// block predicts every rgb pixel and reports mismatches back here
// ----------------------------------------------------------------------------
module tb_yuyv_to_rgb_converter_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_PAIRS = 313;   // plus the directed pairs, about 650 pixels
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 10;    // allow for output stalls
    localparam int IDLE_PCT     = 12;

    logic clk = 1'b0;
    logic rst_n;
    bit   steady_run;                    // set during the stretch with no idling
    int   cycle_count = 0;
    int   mismatch_count;
    int   rgb_pending;

    yuyv_pix_if pix_in_if ();
    yuyv_rgb_if pix_out_if ();

    yuyv_to_rgb_converter_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_in_if),
        .pix_out (pix_out_if)
    );

    yuyv_rgb_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .pix            (pix_in_if),
        .rgb            (pix_out_if),
        .mismatch_count (mismatch_count),
        .rgb_pending    (rgb_pending)
    );

    // 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // run-away guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // output side: back-pressure in about one cycle in eight, none in the steady stretch
    always @(posedge clk)
    begin
        pix_out_if.ready <= steady_run || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // byte with a bias toward the extremes, so that clamping is hit often
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // one pixel request; valid is left high on return so back-to-back
    // requests never lower and raise it in the same step
    task automatic send_pixel(input logic [7:0] y, input logic [7:0] c);
        while (!steady_run && $urandom_range(0, 99) < IDLE_PCT)
        begin
            pix_in_if.valid <= 1'b0;
            @(posedge clk);
        end
        pix_in_if.valid  <= 1'b1;
        pix_in_if.luma   <= y;
        pix_in_if.chroma <= c;
        do
            @(posedge clk);
        while (!pix_in_if.ready);
    endtask

    // even pixel carries cb, odd pixel carries cr
    task automatic send_pair(input logic [7:0] y_even, input logic [7:0] cb,
                             input logic [7:0] y_odd, input logic [7:0] cr);
        send_pixel(y_even, cb);
        send_pixel(y_odd, cr);
    endtask

    initial
    begin
        steady_run        = 1'b0;
        rst_n            <= 1'b0;
        pix_in_if.valid  <= 1'b0;
        pix_in_if.luma   <= '0;
        pix_in_if.chroma <= '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners: saturation high and low on every channel,
        // neutral chroma, black and white luma, small offsets that truncate
        send_pair(8'd0,   8'd0,   8'd0,   8'd0);
        send_pair(8'd255, 8'd255, 8'd255, 8'd255);
        send_pair(8'd0,   8'd128, 8'd255, 8'd128);
        send_pair(8'd255, 8'd0,   8'd0,   8'd255);
        send_pair(8'd0,   8'd255, 8'd255, 8'd0);
        send_pair(8'd128, 8'd128, 8'd128, 8'd128);
        send_pair(8'd16,  8'd128, 8'd235, 8'd128);
        send_pair(8'd1,   8'd129, 8'd1,   8'd127);
        send_pair(8'd200, 8'd60,  8'd90,  8'd240);
        send_pair(8'd255, 8'd255, 8'd0,   8'd0);
        send_pair(8'd0,   8'd0,   8'd255, 8'd255);
        send_pair(8'd85,  8'd170, 8'd170, 8'd85);

        // random pairs, with a long stretch in the middle running flat out
        for (int i = 0; i < RANDOM_PAIRS; i++)
        begin
            steady_run <= (i >= 100 && i < 180);
            send_pair(pick_byte(), pick_byte(), pick_byte(), pick_byte());
        end
        pix_in_if.valid <= 1'b0;
        steady_run      <= 1'b0;

        // let the pending count catch up with the last request, then drain
        @(posedge clk);
        while (rgb_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
